// ===== rtl/qcts_pkg.sv =====
package qcts_pkg;

   // default fixed point format, signed q16.16
   localparam int unsigned DATA_WIDTH_DEF = 32;
   localparam int unsigned FRAC_BITS_DEF  = 16;

   // two bands, two candidate roots per band
   localparam int unsigned BANDS = 2;
   localparam int unsigned LANES = 2 * BANDS;

endpackage

// ===== rtl/quadratic_crossing_time_solver.sv =====
// Smallest strictly positive crossing time of a*t^2+b*t+c against two bands.
//
// Request channel: req_valid / req_stall with the coefficients a, b and the
// upper and lower band constants, signed fixed point (FRAC_BITS fraction bits).
// Response channel: rsp_valid / rsp_stall with rsp_found and rsp_root_time,
// the earlier of the two band roots as unsigned fixed point, saturated at
// all ones, zero when no positive root exists. On a tie the lower band wins.
//
// Pipeline stages in order: one multiply stage, one discriminant stage,
// DATA_WIDTH+1 square root stages (one root bit each), one numerator stage,
// DATA_WIDTH+FRAC_BITS+2 divider stages (one quotient bit each, four
// dividers side by side), one band select stage and the response register.
// Throughput is one request per cycle unless rsp_stall freezes the pipeline.
//
// All stages advance together. When the response register holds a result
// and rsp_stall is high, the whole pipeline freezes and req_stall is raised;
// nothing is dropped or repeated. Synchronous reset clears every valid bit,
// so the pipeline comes out of reset empty.
module quadratic_crossing_time_solver #(
   parameter int unsigned DATA_WIDTH = qcts_pkg::DATA_WIDTH_DEF,
   parameter int unsigned FRAC_BITS  = qcts_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [DATA_WIDTH-1:0] req_coef_a,
   input  logic signed [DATA_WIDTH-1:0] req_coef_b,
   input  logic signed [DATA_WIDTH-1:0] req_coef_c_upper,
   input  logic signed [DATA_WIDTH-1:0] req_coef_c_lower,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_found,
   output logic        [DATA_WIDTH-1:0] rsp_root_time
);
   import qcts_pkg::*;

   localparam int unsigned W   = DATA_WIDTH;
   localparam int unsigned F   = FRAC_BITS;
   localparam int unsigned PW  = 2 * W + 1;  // discriminant
   localparam int unsigned TW  = PW + 2;     // square root trial value
   localparam int unsigned SW  = W + 1;      // discriminant root
   localparam int unsigned NW  = W + 3;      // signed numerator
   localparam int unsigned MW  = W + 2;      // numerator magnitude
   localparam int unsigned DVW = W + 1;      // divisor magnitude
   localparam int unsigned QW  = MW + F;     // dividend and quotient

   typedef struct packed {
      logic [W-1:0]            a;
      logic [W-1:0]            b;
      logic [BANDS-1:0][W-1:0] c;
      logic [BANDS-1:0]        neg;
   } side_type;

   // whole pipeline moves when the response register can take a result
   logic adv;
   logic rsp_valid_ff;
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   function automatic logic [W-1:0] mag_w(input logic [W-1:0] x);
      mag_w = x[W-1] ? (~x + W'(1)) : x;
   endfunction

   // ---------------- multiply stage ----------------
   logic                          v_mul_ff;
   logic [W-1:0]                  mul_a_ff, mul_b_ff;
   logic [BANDS-1:0][W-1:0]       mul_c_ff;
   logic [2*W-1:0]                mul_bb_ff;
   logic [BANDS-1:0][2*W-1:0]     mul_ac_ff;
   logic [W-1:0]                  ma_in, mb_in;
   logic [BANDS-1:0][W-1:0]       mc_in;

   always_comb begin
      ma_in    = mag_w(req_coef_a);
      mb_in    = mag_w(req_coef_b);
      mc_in[0] = mag_w(req_coef_c_upper);
      mc_in[1] = mag_w(req_coef_c_lower);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_mul_ff <= 1'b0;
      end else if (adv) begin
         v_mul_ff <= req_valid;
      end
      if (adv) begin
         mul_a_ff     <= req_coef_a;
         mul_b_ff     <= req_coef_b;
         mul_c_ff[0]  <= req_coef_c_upper;
         mul_c_ff[1]  <= req_coef_c_lower;
         mul_bb_ff    <= (2*W)'(mb_in) * (2*W)'(mb_in);
         mul_ac_ff[0] <= (2*W)'(ma_in) * (2*W)'(mc_in[0]);
         mul_ac_ff[1] <= (2*W)'(ma_in) * (2*W)'(mc_in[1]);
      end
   end

   // ---------------- discriminant stage ----------------
   logic                   v_disc_ff;
   side_type               disc_side_ff;
   logic [BANDS-1:0][PW-1:0] disc_d_ff;
   side_type               disc_side_in;
   logic [BANDS-1:0][PW-1:0] disc_d_in;

   always_comb begin
      logic [PW:0] bb_x, ac4_x;
      logic        differ;
      disc_side_in.a = mul_a_ff;
      disc_side_in.b = mul_b_ff;
      disc_side_in.c = mul_c_ff;
      bb_x = (PW+1)'(mul_bb_ff);
      for (int k = 0; k < BANDS; k++) begin
         ac4_x  = {mul_ac_ff[k], 2'b00};
         differ = (mul_c_ff[k] != '0) && (mul_a_ff[W-1] != mul_c_ff[k][W-1]);
         disc_side_in.neg[k] = !differ && (bb_x < ac4_x);
         disc_d_in[k] = differ ? PW'(bb_x + ac4_x) : PW'(bb_x - ac4_x);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_disc_ff <= 1'b0;
      end else if (adv) begin
         v_disc_ff <= v_mul_ff;
      end
      if (adv) begin
         disc_side_ff <= disc_side_in;
         disc_d_ff    <= disc_d_in;
      end
   end

   // ---------------- square root, one root bit per stage ----------------
   logic                     v_sq_ff    [SW];
   side_type                 sq_side_ff [SW];
   logic [BANDS-1:0][PW-1:0] sq_rem_ff  [SW];
   logic [BANDS-1:0][SW-1:0] sq_root_ff [SW];

   for (genvar j = 0; j < SW; j++) begin : g_sqrt
      localparam int unsigned I = SW - 1 - j;
      logic                     v_src;
      side_type                 side_src;
      logic [BANDS-1:0][PW-1:0] rem_src, sq_rem_in;
      logic [BANDS-1:0][SW-1:0] root_src, sq_root_in;

      if (j == 0) begin : g_first
         assign v_src    = v_disc_ff;
         assign side_src = disc_side_ff;
         assign rem_src  = disc_d_ff;
         assign root_src = '0;
      end else begin : g_next
         assign v_src    = v_sq_ff[j-1];
         assign side_src = sq_side_ff[j-1];
         assign rem_src  = sq_rem_ff[j-1];
         assign root_src = sq_root_ff[j-1];
      end

      // try setting this bit: root^2 grows by 2*root*2^i + 2^(2i)
      always_comb begin
         logic [TW-1:0] trial;
         for (int k = 0; k < BANDS; k++) begin
            trial = (TW'(root_src[k]) << (I + 1)) + (TW'(1) << (2 * I));
            if (TW'(rem_src[k]) >= trial) begin
               sq_rem_in[k]  = PW'(TW'(rem_src[k]) - trial);
               sq_root_in[k] = root_src[k] | (SW'(1) << I);
            end else begin
               sq_rem_in[k]  = rem_src[k];
               sq_root_in[k] = root_src[k];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_sq_ff[j] <= 1'b0;
         end else if (adv) begin
            v_sq_ff[j] <= v_src;
         end
         if (adv) begin
            sq_side_ff[j] <= side_src;
            sq_rem_ff[j]  <= sq_rem_in;
            sq_root_ff[j] <= sq_root_in;
         end
      end
   end

   // ---------------- numerator and divisor stage ----------------
   logic                        v_prep_ff;
   logic [LANES-1:0]            prep_ok_ff, prep_ok_in;
   logic [LANES-1:0][QW-1:0]    prep_dvd_ff, prep_dvd_in;
   logic [LANES-1:0][DVW-1:0]   prep_den_ff, prep_den_in;

   always_comb begin
      side_type      sd;
      logic [NW-1:0] nb, sx, num;
      logic [NW-1:0] mag_num;
      logic [W:0]    den;
      logic          a_zero;
      sd     = sq_side_ff[SW-1];
      a_zero = (sd.a == '0);
      nb     = -{{3{sd.b[W-1]}}, sd.b};
      den    = a_zero ? {sd.b[W-1], sd.b} : {sd.a, 1'b0};
      for (int l = 0; l < LANES; l++) begin
         sx = {2'b00, sq_root_ff[SW-1][l/2]};
         if (a_zero) begin
            num = -{{3{sd.c[l/2][W-1]}}, sd.c[l/2]};
         end else if ((l % 2) == 0) begin
            num = nb + sx;
         end else begin
            num = nb - sx;
         end
         prep_ok_in[l] = (den != '0) && (num != '0) && (num[NW-1] == den[W])
                         && (a_zero ? ((l % 2) == 0) : !sd.neg[l/2]);
         mag_num        = num[NW-1] ? -num : num;
         prep_dvd_in[l] = {mag_num[MW-1:0], F'(0)};
         prep_den_in[l] = den[W] ? -den : den;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_prep_ff <= 1'b0;
      end else if (adv) begin
         v_prep_ff <= v_sq_ff[SW-1];
      end
      if (adv) begin
         prep_ok_ff  <= prep_ok_in;
         prep_dvd_ff <= prep_dvd_in;
         prep_den_ff <= prep_den_in;
      end
   end

   // ---------------- restoring dividers, one quotient bit per stage ----------------
   logic                      v_div_ff   [QW];
   logic [LANES-1:0]          div_ok_ff  [QW];
   logic [LANES-1:0][QW-1:0]  div_dvd_ff [QW];
   logic [LANES-1:0][DVW-1:0] div_den_ff [QW];
   logic [LANES-1:0][DVW-1:0] div_rem_ff [QW];
   logic [LANES-1:0][QW-1:0]  div_quo_ff [QW];

   for (genvar j = 0; j < QW; j++) begin : g_div
      localparam int unsigned I = QW - 1 - j;
      logic                      v_src;
      logic [LANES-1:0]          ok_src;
      logic [LANES-1:0][QW-1:0]  dvd_src, quo_src, div_quo_in;
      logic [LANES-1:0][DVW-1:0] den_src, rem_src, div_rem_in;

      if (j == 0) begin : g_first
         assign v_src   = v_prep_ff;
         assign ok_src  = prep_ok_ff;
         assign dvd_src = prep_dvd_ff;
         assign den_src = prep_den_ff;
         assign rem_src = '0;
         assign quo_src = '0;
      end else begin : g_next
         assign v_src   = v_div_ff[j-1];
         assign ok_src  = div_ok_ff[j-1];
         assign dvd_src = div_dvd_ff[j-1];
         assign den_src = div_den_ff[j-1];
         assign rem_src = div_rem_ff[j-1];
         assign quo_src = div_quo_ff[j-1];
      end

      // shift in the next dividend bit and subtract when it fits
      always_comb begin
         logic [DVW:0] part;
         for (int l = 0; l < LANES; l++) begin
            part = {rem_src[l], dvd_src[l][I]};
            if (part >= {1'b0, den_src[l]}) begin
               div_rem_in[l] = DVW'(part - {1'b0, den_src[l]});
               div_quo_in[l] = quo_src[l] | (QW'(1) << I);
            end else begin
               div_rem_in[l] = DVW'(part);
               div_quo_in[l] = quo_src[l];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_div_ff[j] <= 1'b0;
         end else if (adv) begin
            v_div_ff[j] <= v_src;
         end
         if (adv) begin
            div_ok_ff[j]  <= ok_src;
            div_dvd_ff[j] <= dvd_src;
            div_den_ff[j] <= den_src;
            div_rem_ff[j] <= div_rem_in;
            div_quo_ff[j] <= div_quo_in;
         end
      end
   end

   // ---------------- per band smallest positive root ----------------
   logic                     v_band_ff;
   logic [BANDS-1:0]         band_f_ff, band_f_in;
   logic [BANDS-1:0][QW-1:0] band_q_ff, band_q_in;

   always_comb begin
      logic [QW-1:0] q0, q1;
      logic          p0, p1;
      for (int k = 0; k < BANDS; k++) begin
         q0 = div_quo_ff[QW-1][2*k];
         q1 = div_quo_ff[QW-1][2*k+1];
         p0 = div_ok_ff[QW-1][2*k] && (q0 != '0);
         p1 = div_ok_ff[QW-1][2*k+1] && (q1 != '0);
         band_f_in[k] = p0 || p1;
         if (p0 && p1) begin
            band_q_in[k] = (q1 < q0) ? q1 : q0;
         end else if (p0) begin
            band_q_in[k] = q0;
         end else begin
            band_q_in[k] = q1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_band_ff <= 1'b0;
      end else if (adv) begin
         v_band_ff <= v_div_ff[QW-1];
      end
      if (adv) begin
         band_f_ff <= band_f_in;
         band_q_ff <= band_q_in;
      end
   end

   // ---------------- band choice, saturation and response register ----------------
   logic         rsp_found_ff, rsp_found_in;
   logic [W-1:0] rsp_root_ff, rsp_root_in;

   always_comb begin
      logic [QW-1:0] r;
      priority if (band_f_ff[0] && band_f_ff[1]) begin
         r = (band_q_ff[0] < band_q_ff[1]) ? band_q_ff[0] : band_q_ff[1];
      end else if (band_f_ff[0]) begin
         r = band_q_ff[0];
      end else begin
         r = band_q_ff[1];
      end
      rsp_found_in = |band_f_ff;
      if (!rsp_found_in) begin
         rsp_root_in = '0;
      end else if (r[QW-1:W] != '0) begin
         rsp_root_in = '1;
      end else begin
         rsp_root_in = r[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= v_band_ff;
      end
      if (adv) begin
         rsp_found_ff <= rsp_found_in;
         rsp_root_ff  <= rsp_root_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_root_time = rsp_root_ff;

endmodule

// ===== rtl/qcts_check.sv =====
module qcts_check #(
   parameter int unsigned DATA_WIDTH = qcts_pkg::DATA_WIDTH_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic                  rsp_found,
   input logic [DATA_WIDTH-1:0] rsp_root_time
);
   import qcts_pkg::*;

   // pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // request side stalls exactly while a response is held back
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("request stall does not follow response backpressure");

   // no root means a zero time
   a_zero_time: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_root_time == '0))
      else $error("root time non-zero without a root");

   // a held response keeps its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_found)
                                    && $stable(rsp_root_time)))
      else $error("stalled response changed");

endmodule

bind quadratic_crossing_time_solver qcts_check #(.DATA_WIDTH(DATA_WIDTH)) u_qcts_check (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_found     (rsp_found),
   .rsp_root_time (rsp_root_time)
);
